FILE: sv/double_ended_queue_unit_macros.svh
// Assertion macros for the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define DEQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `DEQ_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

FILE: sv/deq_pkg.sv
// Types, constants and ring index helpers for the double-ended queue.
`default_nettype none

package deq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 7;
  localparam int VAL_W = 32;
  localparam int ACT_W = 3;
  localparam int STS_W = 2;

  typedef enum logic [ACT_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  localparam logic [STS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STS_W-1:0]        status;
    logic                    last;
    logic [CNT_W-1:0]        count;
  } res_t;

  function automatic logic [IDX_W-1:0] ring_inc(logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
  endfunction

  // idx + cnt modulo DEPTH; both operands stay below DEPTH, so one subtract wraps.
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] idx,
                                                logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt);
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/double_ended_queue_unit.sv
// Top level of the double-ended queue of signed 32-bit words.
`default_nettype none

// Bounded double-ended queue of up to DEPTH (64) signed 32-bit words, kept in a
// ring in a single RAM with a front index and a word count. Both sides look like
// a queue: write an input beat with push while full is low, take result beats
// with pop while empty is low. Each input beat carries one action: push front,
// push back, pop front, pop back or dump. Pushes and pops answer with one result
// beat (a pop carries the removed word); a push on a full ring answers overflow
// and a pop on an empty ring answers underflow, leaving the ring unchanged. Dump
// streams every stored word front to back and flags the final beat with last;
// on an empty ring it answers one underflow beat. Action codes 5 to 7 are taken
// and dropped without a result. Every result carries the word count after the
// action. Rate: the back end issues one RAM access per cycle while the result
// queue has room; a dump holds off further commands until its last word is read.
// An input beat passes the command queue, the staged result register and the
// result queue on its way out. A two-entry command queue sits between decode and
// execution and a four-entry result queue holds finished beats, so either side
// may stall without the other losing a beat. No clearing pass runs after reset.
module double_ended_queue_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [deq_pkg::ACT_W-1:0]        action_i,
  input  logic signed [deq_pkg::VAL_W-1:0] value_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [deq_pkg::VAL_W-1:0] value_res_o,
  output logic [deq_pkg::STS_W-1:0]        status_o,
  output logic                             last_o,
  output logic [deq_pkg::CNT_W-1:0]        count_o
);
  import deq_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  // Decode and hold commands until the back end is free.
  deq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Advance the ring and drop finished beats into the result queue.
  deq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign value_res_o = res.value;
  assign status_o    = res.status;
  assign last_o      = res.last;
  assign count_o     = res.count;

endmodule

`default_nettype wire

FILE: sv/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/deq_front.sv
// Front end: accepts input beats, decodes the action and queues commands.
`default_nettype none

module deq_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [deq_pkg::ACT_W-1:0]  action_i,
  input  logic signed [deq_pkg::VAL_W-1:0] value_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output deq_pkg::cmd_t              cmd_o
);
  import deq_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       accept, known, enq, deq;
  op_e        op;

  // Classify the action; unused codes are accepted and dropped here.
  always_comb begin
    known = 1'b1;
    op    = OP_DUMP;
    unique case (action_i)
      OP_PUSH_FRONT: op = OP_PUSH_FRONT;
      OP_PUSH_BACK:  op = OP_PUSH_BACK;
      OP_POP_FRONT:  op = OP_POP_FRONT;
      OP_POP_BACK:   op = OP_POP_BACK;
      OP_DUMP:       op = OP_DUMP;
      default:       known = 1'b0;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign enq         = accept && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign deq         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq) wr_q <= ~wr_q;
      if (deq) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(enq) - 2'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_q] <= '{op: op, value: value_i};
    end
  end

endmodule

`default_nettype wire

FILE: sv/deq_back.sv
// Back end: executes commands on the word ring and queues the result beats.
`default_nettype none
`include "double_ended_queue_unit_macros.svh"

module deq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  deq_pkg::cmd_t cmd_i,
  output logic          empty,
  input  logic          pop,
  output deq_pkg::res_t res_o
);
  import deq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;
  localparam int   OQ_DEPTH = 4;
  localparam int   OQ_AW = 2;

  logic             state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] dump_addr_q, dump_addr_d;
  logic [CNT_W-1:0] dump_left_q, dump_left_d;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_rd_q, s1_rd_d;
  res_t             s1_res_q, s1_res_d;

  res_t             oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_AW:0]   oq_cnt_q;
  logic             oq_pop;
  res_t             oq_in;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic             room, is_full, is_empty;

  deq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Issue only while the result queue can take every beat already in flight.
  assign room     = ((oq_cnt_q + (OQ_AW+1)'(s1_valid_q)) < (OQ_AW+1)'(OQ_DEPTH));
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign cmd_ready_o = (state_q == S_IDLE) && room;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    dump_addr_d = dump_addr_q;
    dump_left_d = dump_left_q;
    ram_we      = 1'b0;
    ram_waddr   = front_q;
    ram_re      = 1'b0;
    ram_raddr   = front_q;
    s1_valid_d  = 1'b0;
    s1_rd_d     = 1'b0;
    s1_res_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && room) begin
          s1_valid_d      = 1'b1;
          s1_res_d.last   = 1'b1;
          s1_res_d.status = STATUS_OK;
          unique case (cmd_i.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                s1_res_d.status = STATUS_FULL;
              end else begin
                front_d   = ring_dec(front_q);
                ram_we    = 1'b1;
                ram_waddr = ring_dec(front_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                s1_res_d.status = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(front_q, count_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                s1_res_d.status = STATUS_EMPTY;
              end else begin
                ram_re  = 1'b1;
                s1_rd_d = 1'b1;
                count_d = count_q - CNT_W'(1);
                if (cmd_i.op == OP_POP_FRONT) begin
                  front_d = ring_inc(front_q);
                end else begin
                  ram_raddr = ring_add(front_q, count_q - CNT_W'(1));
                end
                // Rewind the ring once it drains.
                if (count_q == CNT_W'(1)) front_d = '0;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                s1_res_d.status = STATUS_EMPTY;
              end else begin
                ram_re      = 1'b1;
                s1_rd_d     = 1'b1;
                dump_addr_d = ring_inc(front_q);
                dump_left_d = count_q - CNT_W'(1);
                if (count_q != CNT_W'(1)) begin
                  s1_res_d.last = 1'b0;
                  state_d       = S_DUMP;
                end
              end
            end
            default: s1_valid_d = 1'b0;
          endcase
        end
      end
      S_DUMP: begin
        if (room) begin
          s1_valid_d      = 1'b1;
          s1_rd_d         = 1'b1;
          s1_res_d.status = STATUS_OK;
          ram_re          = 1'b1;
          ram_raddr       = dump_addr_q;
          dump_addr_d     = ring_inc(dump_addr_q);
          dump_left_d     = dump_left_q - CNT_W'(1);
          s1_res_d.last   = (dump_left_q == CNT_W'(1));
          if (dump_left_q == CNT_W'(1)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    s1_res_d.count = count_d;
  end

  // Merge the read word into the staged result as it enters the queue.
  always_comb begin
    oq_in       = s1_res_q;
    oq_in.value = s1_rd_q ? ram_rdata : '0;
  end

  assign empty  = (oq_cnt_q == '0);
  assign oq_pop = pop && !empty;
  assign res_o  = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      front_q    <= '0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      front_q    <= front_d;
      count_q    <= count_d;
      s1_valid_q <= s1_valid_d;
      if (s1_valid_q) oq_wr_q <= oq_wr_q + OQ_AW'(1);
      if (oq_pop)     oq_rd_q <= oq_rd_q + OQ_AW'(1);
      oq_cnt_q <= oq_cnt_q + (OQ_AW+1)'(s1_valid_q) - (OQ_AW+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    dump_addr_q <= dump_addr_d;
    dump_left_q <= dump_left_d;
    s1_rd_q     <= s1_rd_d;
    s1_res_q    <= s1_res_d;
    if (s1_valid_q) oq_q[oq_wr_q] <= oq_in;
  end

  `DEQ_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "count above depth")
  `DEQ_ASSERT_NEVER(a_oq_overflow, clk_i, rst_ni, (oq_cnt_q == (OQ_AW+1)'(OQ_DEPTH)) && s1_valid_q && !pop, "result queue overflow")
  `DEQ_ASSERT(a_dump_nonempty, clk_i, rst_ni, (state_q == S_DUMP) |-> (dump_left_q != '0) && (count_q != '0), "dump with nothing left")
  `DEQ_ASSERT(a_read_issued, clk_i, rst_ni, (s1_valid_q && s1_rd_q) |-> $past(ram_re), "staged read without RAM read")

endmodule

`default_nettype wire
